// ===== src/calu_pkg.sv =====
// package for the checked integer alu: opcodes, status codes and beat types
// no dependencies
package calu_pkg;

    localparam int DATA_WIDTH_DEF = 64;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0,
        OP_SUB = 5'd1,
        OP_MUL = 5'd2,
        OP_DIV = 5'd3,
        OP_MOD = 5'd4,
        OP_AND = 5'd5,
        OP_OR  = 5'd6,
        OP_XOR = 5'd7,
        OP_NOT = 5'd8,
        OP_SHL = 5'd9,
        OP_SHR = 5'd10,
        OP_SAL = 5'd11,
        OP_SAR = 5'd12,
        OP_ROL = 5'd13,
        OP_ROR = 5'd14,
        OP_LT  = 5'd15,
        OP_LE  = 5'd16,
        OP_GT  = 5'd17,
        OP_GE  = 5'd18
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    typedef struct packed {
        logic [4:0]         req_type;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [63:0] result;
        logic [1:0]         status;
    } rsp_t;

endpackage

// ===== src/checked_integer_alu.sv =====
// checked integer alu: pipelined add/sub/mul/div/mod, logic, shifts, compares
// depends on calu_pkg
//
// channel   dir  handshake                 payload
// request   in   start & !busy             req  (req_type, operand_a, operand_b)
// response  out  done, one cycle per beat  rsp  (result, status)
//
// done follows the input register, the stage registers and the output
// register, in that order; a new beat can enter in every cycle
// busy is always low since the pipeline never stalls
// the receiver cannot stall: a result is on rsp only in the cycle done is high
// reset clears the valid bits only; payload registers are not reset
module checked_integer_alu #(
    parameter int DATA_WIDTH = calu_pkg::DATA_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  calu_pkg::req_t req,
    output logic           done,
    output calu_pkg::rsp_t rsp
);
    import calu_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int HL = DW / 2;
    localparam int HH = DW - HL;
    localparam int PW = 2 * DW;

    typedef struct packed {
        op_t           op;
        logic [DW-1:0] res;
        logic [1:0]    st;
        logic [DW-1:0] rem;
        logic [DW-1:0] dq;
        logic [DW-1:0] dsr;
        logic          qneg;
        logic          rneg;
        logic          rdir;
    } stg_t;

    logic                 in_vld_reg;
    op_t                  in_op_reg;
    logic signed [DW-1:0] in_a_reg;
    logic signed [DW-1:0] in_b_reg;

    logic [DW:0] vld_reg;
    stg_t        stg_reg [0:DW];
    stg_t        stg_next [0:DW];

    logic [2*HL-1:0]  ll_reg;
    logic [HL+HH-1:0] lh_reg;
    logic [HL+HH-1:0] hl_reg;
    logic [2*HH-1:0]  hh_reg;
    logic [PW-1:0]    prod_reg;

    logic                 done_reg;
    op_t                  out_op_reg;
    logic signed [63:0]   out_res_reg;
    logic [1:0]           out_st_reg;
    logic signed [DW-1:0] fin_res;

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            vld_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= accept;
            vld_reg    <= {vld_reg[DW-1:0], in_vld_reg};
            done_reg   <= vld_reg[DW];
        end
    end

    always_ff @(posedge clk)
    begin
        in_op_reg <= op_t'(req.req_type);
        in_a_reg  <= req.operand_a[DW-1:0];
        in_b_reg  <= req.operand_b[DW-1:0];
    end

    // first stage: add/sub, logic, shifts and compares, and setup of the divider and multiplier
    always_comb
    begin
        logic [DW:0]   sum;
        logic [DW:0]   dif;
        logic          b_neg;
        logic          b_min;
        logic [DW-1:0] ma;
        logic [DW-1:0] mb;
        logic [DW-1:0] sh_n;
        logic          right;
        logic          a_neg;

        a_neg = in_a_reg[DW-1];
        b_neg = in_b_reg[DW-1];
        b_min = in_b_reg == {1'b1, {(DW-1){1'b0}}};
        sum   = {in_a_reg[DW-1], in_a_reg} + {in_b_reg[DW-1], in_b_reg};
        dif   = {in_a_reg[DW-1], in_a_reg} - {in_b_reg[DW-1], in_b_reg};
        ma    = a_neg ? -in_a_reg : in_a_reg;
        mb    = b_neg ? -in_b_reg : in_b_reg;
        sh_n  = mb;
        right = ((in_op_reg == OP_SHR) || (in_op_reg == OP_SAR) || (in_op_reg == OP_ROR))
                ^ b_neg;

        stg_next[0]      = '0;
        stg_next[0].op   = in_op_reg;
        stg_next[0].st   = ST_OK;
        stg_next[0].dq   = ma;
        stg_next[0].dsr  = mb;
        stg_next[0].qneg = a_neg ^ b_neg;
        stg_next[0].rneg = a_neg;
        stg_next[0].rdir = right;

        case (in_op_reg)
            OP_ADD:
            begin
                if (sum[DW] != sum[DW-1])
                    stg_next[0].st = ST_OVF;
                stg_next[0].res = sum[DW-1:0];
            end
            OP_SUB:
            begin
                if (dif[DW] != dif[DW-1])
                    stg_next[0].st = ST_OVF;
                stg_next[0].res = dif[DW-1:0];
            end
            OP_DIV, OP_MOD:
            begin
                if (in_b_reg == '0)
                    stg_next[0].st = ST_DIVZ;
                else if (in_a_reg == {1'b1, {(DW-1){1'b0}}} && in_b_reg == '1)
                    stg_next[0].st = ST_OVF;
            end
            OP_AND: stg_next[0].res = in_a_reg & in_b_reg;
            OP_OR:  stg_next[0].res = in_a_reg | in_b_reg;
            OP_XOR: stg_next[0].res = in_a_reg ^ in_b_reg;
            OP_NOT: stg_next[0].res = ~in_a_reg;
            OP_SHL, OP_SHR, OP_SAL, OP_SAR:
            begin
                if (b_min)
                    stg_next[0].st = ST_OVF;
                if (!right)
                    stg_next[0].res = in_a_reg << sh_n;
                else if (in_op_reg == OP_SAR && !b_neg && a_neg)
                    stg_next[0].res = ~((~in_a_reg) >> sh_n);
                else if (in_op_reg == OP_SAL && b_neg && a_neg)
                    stg_next[0].res = ~((~in_a_reg) >> sh_n);
                else
                    stg_next[0].res = in_a_reg >> sh_n;
            end
            OP_ROL, OP_ROR:
            begin
                // the divider reduces the count modulo the width
                if (b_min)
                    stg_next[0].st = ST_OVF;
                stg_next[0].res = in_a_reg;
                stg_next[0].dq  = sh_n;
                stg_next[0].dsr = DW'(DW);
            end
            OP_LT:  stg_next[0].res = DW'(in_a_reg <  in_b_reg);
            OP_LE:  stg_next[0].res = DW'(in_a_reg <= in_b_reg);
            OP_GT:  stg_next[0].res = DW'(in_a_reg >  in_b_reg);
            OP_GE:  stg_next[0].res = DW'(in_a_reg >= in_b_reg);
            default: stg_next[0].res = '0;
        endcase
    end

    // multiplier partial products, aligned with stage 1
    always_ff @(posedge clk)
    begin
        ll_reg <= stg_reg[0].dq[HL-1:0]  * stg_reg[0].dsr[HL-1:0];
        lh_reg <= stg_reg[0].dq[HL-1:0]  * stg_reg[0].dsr[DW-1:HL];
        hl_reg <= stg_reg[0].dq[DW-1:HL] * stg_reg[0].dsr[HL-1:0];
        hh_reg <= stg_reg[0].dq[DW-1:HL] * stg_reg[0].dsr[DW-1:HL];
        prod_reg <= PW'(ll_reg) + (PW'(lh_reg) << HL) + (PW'(hl_reg) << HL)
                    + (PW'(hh_reg) << (2 * HL));
    end

    // divider: one quotient bit per stage, the multiply result joins at stage 3
    for (genvar k = 0; k < DW; k++)
    begin : g_div
        always_comb
        begin
            logic [DW:0]   t;
            logic          ge;
            logic [PW-1:0] lim;

            t  = {stg_reg[k].rem, stg_reg[k].dq[DW-1]};
            ge = t >= {1'b0, stg_reg[k].dsr};
            stg_next[k+1]     = stg_reg[k];
            stg_next[k+1].rem = ge ? DW'(t - {1'b0, stg_reg[k].dsr}) : t[DW-1:0];
            stg_next[k+1].dq  = {stg_reg[k].dq[DW-2:0], ge};
            lim = stg_reg[k].qneg ? (PW'(1) << (DW - 1)) : ((PW'(1) << (DW - 1)) - PW'(1));
            if (k == 2 && stg_reg[k].op == OP_MUL)
            begin
                if (prod_reg > lim)
                    stg_next[k+1].st = ST_OVF;
                stg_next[k+1].res = stg_reg[k].qneg ? -prod_reg[DW-1:0] : prod_reg[DW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= DW; i++)
        begin
            stg_reg[i] <= stg_next[i];
        end
    end

    // final stage: quotient and remainder signs, rotates, zero on error
    always_comb
    begin
        logic [PW-1:0] rv;
        logic [PW-1:0] rl;
        logic [PW-1:0] rr;

        rv = {stg_reg[DW].res, stg_reg[DW].res};
        rl = rv << stg_reg[DW].rem;
        rr = rv >> stg_reg[DW].rem;
        case (stg_reg[DW].op)
            OP_DIV: fin_res = stg_reg[DW].qneg ? -stg_reg[DW].dq : stg_reg[DW].dq;
            OP_MOD: fin_res = stg_reg[DW].rneg ? -stg_reg[DW].rem : stg_reg[DW].rem;
            OP_ROL, OP_ROR:
                fin_res = stg_reg[DW].rdir ? rr[DW-1:0] : rl[PW-1:DW];
            default: fin_res = stg_reg[DW].res;
        endcase
        if (stg_reg[DW].st != ST_OK)
            fin_res = '0;
    end

    always_ff @(posedge clk)
    begin
        out_op_reg  <= stg_reg[DW].op;
        out_res_reg <= 64'(fin_res);
        out_st_reg  <= stg_reg[DW].st;
    end

    assign done       = done_reg;
    assign rsp.result = out_res_reg;
    assign rsp.status = out_st_reg;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == ST_OK || rsp.status == ST_OVF || rsp.status == ST_DIVZ))
        else $error("status code out of range");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_OK) |-> (rsp.result == '0))
        else $error("error beat with nonzero result");

    a_divz_op: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_DIVZ) |-> (out_op_reg == OP_DIV || out_op_reg == OP_MOD))
        else $error("division by zero reported for a non-divide beat");

    a_cmp_bool: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (out_op_reg == OP_LT || out_op_reg == OP_LE || out_op_reg == OP_GT
                  || out_op_reg == OP_GE)) |-> (rsp.result == 64'sd0 || rsp.result == 64'sd1))
        else $error("compare result not 0 or 1");

endmodule
